@@ rtl/core/sync_length_xor_deframer_unit_defines.svh @@
// assertion macros for the sync-word length-framed deframer
// used by the top level only, expects clk and rst_n in scope
`ifndef SYNC_LENGTH_XOR_DEFRAMER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_XOR_DEFRAMER_UNIT_DEFINES_SVH

// condition must hold at every edge outside reset
`define SLXD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define SLXD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/slxd_pkg.sv @@
// shared types and constants of the sync-word length-framed deframer
// no dependencies
package slxd_pkg;

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hAA;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd4;
    localparam logic [BYTE_W-1:0] HEADER_LEN    = 8'd3;

    // one queued command: a single result, or a header giving three results
    typedef struct packed {
        logic                triple;
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   sync0;
        logic [BYTE_W-1:0]   sync1;
        logic                first;
        logic                last;
        logic [STATUS_W-1:0] status;
    } slxd_cmd_t;

endpackage

@@ rtl/core/slxd_front.sv @@
// front end: sync hunt, length decode, checksum and command generation
// depends on slxd_pkg
module slxd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    input  logic [slxd_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              cfg_we,
    input  logic [slxd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slxd_pkg::BYTE_W-1:0]       cfg_data,
    output logic                              cmd_valid,
    output slxd_pkg::slxd_cmd_t               cmd
);
    import slxd_pkg::*;

    localparam logic [1:0] PH_HUNT1 = 2'd0;
    localparam logic [1:0] PH_HUNT2 = 2'd1;
    localparam logic [1:0] PH_LEN   = 2'd2;
    localparam logic [1:0] PH_BODY  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] seen_reg, seen_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] sync_first_reg, sync_first_next;
    logic [BYTE_W-1:0] sync_second_reg, sync_second_next;

    logic [BYTE_W-1:0] body_xor;
    logic [BYTE_W-1:0] body_seen;

    assign body_xor  = xor_reg ^ in_byte;
    assign body_seen = seen_reg + BYTE_W'(1);

    always_comb
    begin
        sync_first_next  = sync_first_reg;
        sync_second_next = sync_second_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_next  = cfg_data;
                CFG_SYNC_SECOND: sync_second_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        xor_next    = xor_reg;
        cmd_valid   = 1'b0;
        cmd.triple  = 1'b0;
        cmd.data    = in_byte;
        cmd.sync0   = sync_first_reg;
        cmd.sync1   = sync_second_reg;
        cmd.first   = 1'b0;
        cmd.last    = 1'b0;
        cmd.status  = ST_INSIDE;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (in_byte == sync_first_reg)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    // second-sync test takes precedence when both values match
                    if (in_byte == sync_second_reg)
                        phase_next = PH_LEN;
                    else if (in_byte == sync_first_reg)
                        phase_next = PH_HUNT2;
                    else
                        phase_next = PH_HUNT1;
                end
                PH_LEN:
                begin
                    phase_next = PH_HUNT1;
                    if (in_byte == '0)
                    begin
                        // zero length: silent return to the hunt
                    end
                    else if (in_byte < MIN_FRAME_LEN)
                    begin
                        cmd_valid  = 1'b1;
                        cmd.first  = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.status = ST_BAD;
                    end
                    else
                    begin
                        cmd_valid   = 1'b1;
                        cmd.triple  = 1'b1;
                        phase_next  = PH_BODY;
                        length_next = in_byte;
                        seen_next   = HEADER_LEN;
                        xor_next    = sync_first_reg ^ sync_second_reg ^ in_byte;
                    end
                end
                PH_BODY:
                begin
                    cmd_valid = 1'b1;
                    xor_next  = body_xor;
                    seen_next = body_seen;
                    if (body_seen >= length_reg)
                    begin
                        cmd.last   = 1'b1;
                        cmd.status = (body_xor == '0) ? ST_GOOD : ST_BAD;
                        phase_next = PH_HUNT1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT1;
            length_reg      <= '0;
            seen_reg        <= '0;
            xor_reg         <= '0;
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            length_reg      <= length_next;
            seen_reg        <= seen_next;
            xor_reg         <= xor_next;
            sync_first_reg  <= sync_first_next;
            sync_second_reg <= sync_second_next;
        end
    end

endmodule

@@ rtl/core/slxd_cmd_fifo.sv @@
// command queue between front and back end, flip-flop storage
// depends on slxd_pkg
module slxd_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  slxd_pkg::slxd_cmd_t  wr_data,
    output logic                 is_full,
    input  logic                 rd_en,
    output logic                 rd_valid,
    output slxd_pkg::slxd_cmd_t  rd_data
);
    import slxd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slxd_cmd_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/slxd_back.sv @@
// back end: expands queued commands into result transfers, holds the output
// depends on slxd_pkg
module slxd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  slxd_pkg::slxd_cmd_t            q_data,
    output logic                           q_take,
    output logic                           res_empty,
    input  logic                           res_pop,
    output logic [slxd_pkg::BYTE_W-1:0]    out_byte,
    output logic                           first_mark,
    output logic                           last_mark,
    output logic [slxd_pkg::STATUS_W-1:0]  frame_status
);
    import slxd_pkg::*;

    localparam logic [1:0] SUB_SYNC0 = 2'd0;
    localparam logic [1:0] SUB_SYNC1 = 2'd1;
    localparam logic [1:0] SUB_LEN   = 2'd2;

    slxd_cmd_t  cur_reg, cur_next;
    logic       valid_reg, valid_next;
    logic [1:0] sub_reg, sub_next;

    logic final_sub;
    logic load;

    assign final_sub = !cur_reg.triple || (sub_reg == SUB_LEN);
    assign load      = !valid_reg || (res_pop && final_sub);
    assign q_take    = load && q_valid;
    assign res_empty = !valid_reg;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        sub_next   = sub_reg;
        if (load)
        begin
            valid_next = q_valid;
            cur_next   = q_data;
            sub_next   = SUB_SYNC0;
        end
        else if (res_pop)
            sub_next = sub_reg + 2'd1;
    end

    always_comb
    begin
        out_byte     = cur_reg.data;
        first_mark   = cur_reg.first;
        last_mark    = cur_reg.last;
        frame_status = cur_reg.status;
        if (cur_reg.triple)
        begin
            first_mark   = 1'b0;
            last_mark    = 1'b0;
            frame_status = ST_INSIDE;
            unique case (sub_reg)
                SUB_SYNC0:
                begin
                    out_byte   = cur_reg.sync0;
                    first_mark = 1'b1;
                end
                SUB_SYNC1: out_byte = cur_reg.sync1;
                default:   out_byte = cur_reg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= SUB_SYNC0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

@@ rtl/core/sync_length_xor_deframer_unit.sv @@
// Sync-word length-framed XOR-checksum deframer. Takes one received byte per
// cycle whenever full is low; full rises only when the QUEUE_DEPTH-entry
// command queue between the front end and the result stage has no room. Each
// frame body byte gives one result out; the length byte of a frame expands
// into three results (both sync bytes and the length), which the result stage
// hands out one per pop, so a steady stream of frames is accepted at one byte
// per cycle while results are popped as they appear, the queue absorbing the
// header burst. A result is written into the queue and then loaded into the
// result stage register before it appears on the ports.
// cfg_ready is always high; registers take effect on the next comparison.
// No clearing pass after reset.
`include "sync_length_xor_deframer_unit_defines.svh"

module sync_length_xor_deframer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [slxd_pkg::BYTE_W-1:0]       in_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [slxd_pkg::BYTE_W-1:0]       out_byte,
    output logic                              first_mark,
    output logic                              last_mark,
    output logic [slxd_pkg::STATUS_W-1:0]     frame_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slxd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slxd_pkg::BYTE_W-1:0]       cfg_data
);
    import slxd_pkg::*;

    logic      byte_valid;
    logic      cmd_valid;
    slxd_cmd_t cmd;
    logic      q_full;
    logic      q_valid;
    logic      q_take;
    slxd_cmd_t q_data;

    assign cfg_ready  = 1'b1;
    assign full       = q_full;
    assign byte_valid = push && !q_full;

    slxd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .in_byte    (in_byte),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    slxd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_valid),
        .wr_data  (cmd),
        .is_full  (q_full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    slxd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_take       (q_take),
        .res_empty    (empty),
        .res_pop      (pop),
        .out_byte     (out_byte),
        .first_mark   (first_mark),
        .last_mark    (last_mark),
        .frame_status (frame_status)
    );

    // a command is only produced for an accepted byte, never into a full queue
    `SLXD_ASSERT_ALWAYS(a_no_push_when_full,
                        !(cmd_valid && q_full),
                        "command written to full queue")

    // a waiting result is not lost while nobody takes it
    `SLXD_ASSERT_NEXT(a_result_held,
                      !empty && !pop,
                      !empty,
                      "waiting result vanished")

    // a frame opening that is not a rejection carries inside status
    `SLXD_ASSERT_ALWAYS(a_first_inside,
                        empty || !first_mark || last_mark || (frame_status == ST_INSIDE),
                        "bad status on frame start")

endmodule
